// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the priority queue.
// Depends on nothing; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- hw/rtl/spq_pkg.sv -----
// Shared constants, codes and types of the stable priority queue.
// Depends on nothing; used by the interfaces, the cell and the top level.
package spq_pkg;

   // Defaults of the top-level parameters.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int TAG_WIDTH_DEFAULT = 16;

   // Fixed widths of the word fields.
   localparam int TAG_FIELD_W = 16;
   localparam int LEVEL_W     = 3;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;

   // Least urgent level; out-of-range levels are mapped to it.
   localparam logic [LEVEL_W-1:0] LEVEL_LOWEST = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 3'd0;

   // Request kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // Operation broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic               insert;
      logic               remove;
      logic [LEVEL_W-1:0] level;
   } cmd_type;

endpackage

// ----- hw/rtl/spq_ifs.sv -----
// Valid/ready channel interfaces for the request and response words.
// Depends on spq_pkg for the field widths.
interface spq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [spq_pkg::TAG_FIELD_W-1:0]  tag;
   logic [spq_pkg::LEVEL_W-1:0]      level;

   modport source (output valid, output kind, output tag, output level, input ready);
   modport sink   (input valid, input kind, input tag, input level, output ready);
endinterface

interface spq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [spq_pkg::STATUS_W-1:0]     status;
   logic [spq_pkg::TAG_FIELD_W-1:0]  out_tag;
   logic [spq_pkg::LEVEL_W-1:0]      out_level;
   logic [spq_pkg::OCC_W-1:0]        occupancy;

   modport source (output valid, output status, output out_tag, output out_level,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_tag, input out_level,
                   input occupancy, output ready);
endinterface

// ----- hw/rtl/stable_priority_queue.sv -----
// Stable priority queue: a row of DEPTH sorted cells, head in the first cell.
// Latency: the response word is valid the cycle after the request is accepted.
// Throughput: one request per cycle while the response output is not stalled; every cell
// compares its level with the incoming one in parallel and the whole row shifts together.
// Reset clears the entry count and the response valid; cell contents are
// left undefined and are only read after they were written.
`include "assert_macros.svh"

module stable_priority_queue #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
   parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = (TAG_WIDTH > spq_pkg::TAG_FIELD_W) ? TAG_WIDTH
                                                             : spq_pkg::TAG_FIELD_W;

   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [spq_pkg::TAG_FIELD_W-1:0] out_tag_ff, out_tag_in;
   logic [spq_pkg::LEVEL_W-1:0]     out_level_ff, out_level_in;
   logic [spq_pkg::OCC_W-1:0]       occ_ff, occ_in;

   logic                            accept, full, empty;
   logic [spq_pkg::LEVEL_W-1:0]     norm_level;
   logic [WIDE_W-1:0]               req_tag_wide, head_tag_wide;
   logic [TAG_WIDTH-1:0]            new_tag;
   logic [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;
   spq_pkg::cmd_type                cmd;

   // Chain buses: cell i sits at index i+1, with a boundary slot at each end.
   logic                            keep_chain  [0:DEPTH];
   logic [TAG_WIDTH-1:0]            chain_tag   [0:DEPTH+1];
   logic [spq_pkg::LEVEL_W-1:0]     chain_level [0:DEPTH+1];

   // The output register frees the input side whenever it is empty or drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign empty        = (count_ff == '0);

   // Levels outside one to five are treated as the least urgent level.
   assign norm_level = ((req_ch.level == spq_pkg::LEVEL_NONE) ||
                        (req_ch.level > spq_pkg::LEVEL_LOWEST))
                       ? spq_pkg::LEVEL_LOWEST : req_ch.level;

   // Tags are stored at TAG_WIDTH bits and returned in the 16-bit field.
   assign req_tag_wide = WIDE_W'(req_ch.tag);
   assign new_tag      = req_tag_wide[TAG_WIDTH-1:0];

   assign cmd.insert = accept && (req_ch.kind == spq_pkg::KIND_INSERT) && !full;
   assign cmd.remove = accept && (req_ch.kind == spq_pkg::KIND_REMOVE) && !empty;
   assign cmd.level  = norm_level;

   // Boundary slots of the chain.
   assign keep_chain[0]      = 1'b1;
   assign chain_tag[0]       = '0;
   assign chain_level[0]     = spq_pkg::LEVEL_NONE;
   assign chain_tag[DEPTH+1]   = '0;
   assign chain_level[DEPTH+1] = spq_pkg::LEVEL_NONE;

   // The row of cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell #(
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_tag    (new_tag),
         .occupied   (CNT_W'(i) < count_ff),
         .prev_keep  (keep_chain[i]),
         .prev_tag   (chain_tag[i]),
         .prev_level (chain_level[i]),
         .next_tag   (chain_tag[i+2]),
         .next_level (chain_level[i+2]),
         .keep       (keep_chain[i+1]),
         .tag        (chain_tag[i+1]),
         .level      (chain_level[i+1])
      );
   end

   assign head_tag_wide = WIDE_W'(chain_tag[1]);

   // Entry count and response word for the accepted request.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_tag_in   = out_tag_ff;
      out_level_in = out_level_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_tag_in   = '0;
         out_level_in = spq_pkg::LEVEL_NONE;
         if (req_ch.kind == spq_pkg::KIND_INSERT) begin
            status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
         end else if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            status_in    = spq_pkg::ST_REMOVED;
            out_tag_in   = head_tag_wide[spq_pkg::TAG_FIELD_W-1:0];
            out_level_in = chain_level[1];
         end
      end
   end

   assign occ_wide = (CNT_W + spq_pkg::OCC_W)'(count_in);
   assign occ_in   = accept ? occ_wide[spq_pkg::OCC_W-1:0] : occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_tag_ff   <= out_tag_in;
      out_level_ff <= out_level_in;
      occ_ff       <= occ_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.out_tag   = out_tag_ff;
   assign rsp_ch.out_level = out_level_ff;
   assign rsp_ch.occupancy = occ_ff;

   // The count never passes the number of cells.
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "count above depth")
   // An accepted insert into a queue with room grows it by one.
   `ASSERT_AT(a_insert_grows, clock, reset, cmd.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not grow queue")
   // The two head cells stay in level order.
   `ASSERT_AT(a_head_sorted, clock, reset, (count_ff >= CNT_W'(2)) |-> (chain_level[1] <= chain_level[2]), "head cells out of order")
   // A removed word carries a level of one to five.
   `ASSERT_AT(a_removed_level, clock, reset, (rsp_valid_ff && (status_ff == spq_pkg::ST_REMOVED)) |-> ((out_level_ff != spq_pkg::LEVEL_NONE) && (out_level_ff <= spq_pkg::LEVEL_LOWEST)), "removed level out of range")

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted shift-register queue.
// Depends on spq_pkg for the command type and the level width.
module spq_cell #(
   parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  spq_pkg::cmd_type            cmd,
   input  logic [TAG_WIDTH-1:0]        new_tag,
   input  logic                        occupied,
   input  logic                        prev_keep,
   input  logic [TAG_WIDTH-1:0]        prev_tag,
   input  logic [spq_pkg::LEVEL_W-1:0] prev_level,
   input  logic [TAG_WIDTH-1:0]        next_tag,
   input  logic [spq_pkg::LEVEL_W-1:0] next_level,
   output logic                        keep,
   output logic [TAG_WIDTH-1:0]        tag,
   output logic [spq_pkg::LEVEL_W-1:0] level
);

   logic [TAG_WIDTH-1:0]        tag_ff, tag_in;
   logic [spq_pkg::LEVEL_W-1:0] level_ff, level_in;

   // An occupied slot whose level is not above the new one stays ahead of it,
   // which keeps equal levels in arrival order.
   assign keep = occupied && (level_ff <= cmd.level);

   // Insert: hold, take the new word at the boundary, or shift in from the
   // left. Remove: shift in from the right.
   always_comb begin
      tag_in   = tag_ff;
      level_in = level_ff;
      if (cmd.insert) begin
         if (!keep) begin
            if (prev_keep) begin
               tag_in   = new_tag;
               level_in = cmd.level;
            end else begin
               tag_in   = prev_tag;
               level_in = prev_level;
            end
         end
      end else if (cmd.remove) begin
         tag_in   = next_tag;
         level_in = next_level;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      level_ff <= level_in;
   end

   assign tag   = tag_ff;
   assign level = level_ff;

endmodule
